[design/bfa_pkg.sv]
package bfa_pkg;

   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   localparam logic [COUNT_W-1:0] BITS_IN_USE_RESET = 11'd1024;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] bit_index;
      logic [COUNT_W-1:0] reserve_count;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  found_index;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LOCATE,
      S_CLEAR,
      S_FILL
   } state_type;

endpackage

[design/bitmap_first_fit_allocator.sv]
// First-fit bitmap allocator with one bit per unit, held in a single-port-write,
// registered-read map memory. A command is taken when start is high and busy is
// low; exactly one result follows, shown for one cycle with rsp_valid, and it
// cannot be held off. Alloc reads one map word per cycle until it finds the
// first free bit or reports full. Free steps through the words to reach the
// target. Init rewrites every word. Out-of-range frees, an alloc at a zero
// limit and unused command codes answer on the cycle after start. After reset
// the map is cleared by a fill pass over every word during which busy is high;
// csr writes are taken at any time.
module bitmap_first_fit_allocator #(
   parameter int WORD_BITS = 32,
   parameter int MAP_WORDS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bfa_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output bfa_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [bfa_pkg::COUNT_W-1:0]       csr_wdata
);

   localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int TOTAL_BITS = MAP_WORDS * WORD_BITS;

   localparam logic [bfa_pkg::COUNT_W-1:0] WORD_CNT  = bfa_pkg::COUNT_W'(WORD_BITS);
   localparam logic [bfa_pkg::INDEX_W-1:0] WORD_STEP = bfa_pkg::INDEX_W'(WORD_BITS);
   localparam logic [AW-1:0]               LAST_WORD = AW'(MAP_WORDS - 1);

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   bfa_pkg::state_type              state_ff, state_in;
   logic [AW-1:0]                   word_ff, word_in;
   logic [bfa_pkg::INDEX_W-1:0]     base_ff, base_in;
   logic [bfa_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;
   logic                            quiet_ff, quiet_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bfa_pkg::rsp_type                rsp_ff, rsp_in;
   logic [bfa_pkg::COUNT_W-1:0]     csr_ff;

   logic [bfa_pkg::COUNT_W-1:0]     limit;
   logic [WORD_BITS-1:0]            fill;
   logic [WORD_BITS-1:0]            point;
   logic                            hit;
   logic [OFF_W-1:0]                hit_off;
   logic [WORD_BITS-1:0]            hit_mask;

   bfa_word_scan #(
      .WORD_BITS (WORD_BITS)
   ) u_scan (
      .map_word (rd_data_ff),
      .count    (cnt_ff),
      .fill     (fill),
      .point    (point),
      .hit      (hit),
      .hit_off  (hit_off),
      .hit_mask (hit_mask)
   );

   always_comb begin
      if (int'(csr_ff) < TOTAL_BITS) begin
         limit = csr_ff;
      end else begin
         limit = bfa_pkg::COUNT_W'(TOTAL_BITS);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= map_mem[rd_addr];
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= bfa_pkg::BITS_IN_USE_RESET;
      end else if (csr_we) begin
         csr_ff <= csr_wdata;
      end
   end

   // reset starts a silent fill pass that clears the map
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfa_pkg::S_FILL;
         word_ff      <= '0;
         base_ff      <= '0;
         cnt_ff       <= '0;
         quiet_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         quiet_ff     <= quiet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      quiet_in     = quiet_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status = bfa_pkg::STAT_OK;
      rd_addr      = word_ff;
      wr_en        = 1'b0;
      wr_addr      = word_ff;
      wr_data      = rd_data_ff;
      unique case (state_ff)
         bfa_pkg::S_IDLE: begin
            rd_addr = '0;
            if (start) begin
               unique case (req_data.cmd)
                  bfa_pkg::CMD_ALLOC: begin
                     if (limit == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = bfa_pkg::STAT_FULL;
                     end else begin
                        state_in = bfa_pkg::S_SCAN;
                        word_in  = '0;
                        base_in  = '0;
                        cnt_in   = limit;
                     end
                  end
                  bfa_pkg::CMD_FREE: begin
                     if ({1'b0, req_data.bit_index} >= limit) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = bfa_pkg::STAT_RANGE;
                     end else begin
                        state_in = bfa_pkg::S_LOCATE;
                        word_in  = '0;
                        cnt_in   = {1'b0, req_data.bit_index};
                     end
                  end
                  bfa_pkg::CMD_INIT: begin
                     state_in = bfa_pkg::S_FILL;
                     word_in  = '0;
                     cnt_in   = req_data.reserve_count;
                     quiet_in = 1'b0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         bfa_pkg::S_SCAN: begin
            // next word is read ahead while this one is checked
            rd_addr = word_ff + AW'(1);
            if (hit) begin
               wr_en              = 1'b1;
               wr_data            = rd_data_ff | hit_mask;
               rsp_valid_in       = 1'b1;
               rsp_in.found_index = base_ff + bfa_pkg::INDEX_W'(hit_off);
               state_in           = bfa_pkg::S_IDLE;
            end else if (cnt_ff <= WORD_CNT) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = bfa_pkg::STAT_FULL;
               state_in      = bfa_pkg::S_IDLE;
            end else begin
               word_in = word_ff + AW'(1);
               base_in = base_ff + WORD_STEP;
               cnt_in  = cnt_ff - WORD_CNT;
            end
         end
         bfa_pkg::S_LOCATE: begin
            if (cnt_ff >= WORD_CNT) begin
               cnt_in  = cnt_ff - WORD_CNT;
               word_in = word_ff + AW'(1);
            end else begin
               state_in = bfa_pkg::S_CLEAR;
            end
         end
         bfa_pkg::S_CLEAR: begin
            wr_en        = 1'b1;
            wr_data      = rd_data_ff & ~point;
            rsp_valid_in = 1'b1;
            state_in     = bfa_pkg::S_IDLE;
         end
         bfa_pkg::S_FILL: begin
            wr_en   = 1'b1;
            wr_data = fill;
            if (cnt_ff > WORD_CNT) begin
               cnt_in = cnt_ff - WORD_CNT;
            end else begin
               cnt_in = '0;
            end
            if (word_ff == LAST_WORD) begin
               rsp_valid_in = !quiet_ff;
               quiet_in     = 1'b0;
               state_in     = bfa_pkg::S_IDLE;
            end else begin
               word_in = word_ff + AW'(1);
            end
         end
         default: begin
            state_in = bfa_pkg::S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != bfa_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither started nor answered");

   a_full_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == bfa_pkg::STAT_FULL) |-> (rsp_data.found_index == '0))
      else $error("full result carries a nonzero index");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfa_pkg::S_SCAN) |-> (cnt_ff != '0))
      else $error("scan running with no bits left");

   a_clear_offset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfa_pkg::S_CLEAR) |-> (cnt_ff < WORD_CNT && $onehot(point)))
      else $error("free offset outside the word");
`endif

endmodule

[design/bfa_word_scan.sv]
module bfa_word_scan #(
   parameter int WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0]          map_word,
   input  logic [bfa_pkg::COUNT_W-1:0]   count,
   output logic [WORD_BITS-1:0]          fill,
   output logic [WORD_BITS-1:0]          point,
   output logic                          hit,
   output logic [$clog2(WORD_BITS)-1:0]  hit_off,
   output logic [WORD_BITS-1:0]          hit_mask
);

   localparam int OFF_W = $clog2(WORD_BITS);

   // offset order is byte lane kept, msb first within each byte
   always_comb begin
      int pos;
      pos      = 0;
      fill     = '0;
      point    = '0;
      hit      = 1'b0;
      hit_off  = '0;
      hit_mask = '0;
      for (int off = WORD_BITS - 1; off >= 0; off--) begin
         pos        = (off & ~7) | (7 - (off & 7));
         fill[pos]  = bfa_pkg::COUNT_W'(off) < count;
         point[pos] = bfa_pkg::COUNT_W'(off) == count;
         if (!map_word[pos] && (bfa_pkg::COUNT_W'(off) < count)) begin
            hit      = 1'b1;
            hit_off  = OFF_W'(off);
            hit_mask = WORD_BITS'(1) << pos;
         end
      end
   end

endmodule
